// File: src/assert_macros.svh
// assertion macros used by the scroller back end rtl
// no dependencies; included inside the ldms_back module body
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LDMS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LDMS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ldms_pkg.sv
// shared types, constants and font/orientation functions for the digit scroller
// no dependencies; imported by every scroller module
`timescale 1ns / 1ps

package ldms_pkg;

  localparam int MAX_DIGITS_DEF = 5;
  localparam int MATRIX_WIDTH   = 5;
  localparam int CELLS          = MATRIX_WIDTH * MATRIX_WIDTH;
  localparam int VALUE_W        = 16;
  localparam int BCD_DIGITS     = 5;
  localparam int BCD_W          = BCD_DIGITS * 4;
  localparam int CONV_CNT_W     = $clog2(VALUE_W);
  localparam int QUEUE_DEPTH    = 2;

  // clears the rightmost column of every row after a left shift
  localparam logic [CELLS-1:0] KEEP_AFTER_SHIFT = 25'h0F7BDEF;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
  } num_word_t;

  typedef struct packed {
    logic [CELLS-1:0] led_mask;
    logic             last;
  } frame_word_t;

  typedef struct packed {
    logic [1:0] orientation;
  } cfg_word_t;

  // one converted number handed from front to back
  typedef struct packed {
    logic [BCD_DIGITS-1:0][3:0] bcd;
    logic [2:0]                 count;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  typedef enum logic [1:0] {
    ORIENT_NORMAL,
    ORIENT_RIGHT,
    ORIENT_LEFT,
    ORIENT_FLIP
  } orient_t;

  // font rom: {row4, row3, row2, row1, row0}, bit c of a row is column c
  function automatic logic [CELLS-1:0] glyph_rows(input logic [3:0] digit);
    case (digit)
      4'd0:    glyph_rows = {5'h0E, 5'h0A, 5'h0A, 5'h0A, 5'h0E};
      4'd1:    glyph_rows = {5'h0E, 5'h04, 5'h04, 5'h06, 5'h04};
      4'd2:    glyph_rows = {5'h0E, 5'h02, 5'h0E, 5'h08, 5'h0E};
      4'd3:    glyph_rows = {5'h0E, 5'h08, 5'h0E, 5'h08, 5'h0E};
      4'd4:    glyph_rows = {5'h08, 5'h08, 5'h0E, 5'h0A, 5'h0A};
      4'd5:    glyph_rows = {5'h0E, 5'h08, 5'h0E, 5'h02, 5'h0E};
      4'd6:    glyph_rows = {5'h0E, 5'h0A, 5'h0E, 5'h02, 5'h0E};
      4'd7:    glyph_rows = {5'h08, 5'h08, 5'h08, 5'h08, 5'h0E};
      4'd8:    glyph_rows = {5'h0E, 5'h0A, 5'h0E, 5'h0A, 5'h0E};
      4'd9:    glyph_rows = {5'h0E, 5'h08, 5'h0E, 5'h0A, 5'h0E};
      default: glyph_rows = '0;
    endcase
  endfunction

  // glyph column col placed in the right edge column of the frame
  function automatic logic [CELLS-1:0] entering_column(input logic [3:0] digit,
                                                       input logic [2:0] col);
    logic [CELLS-1:0] rows;
    logic [4:0]       row;
    logic [CELLS-1:0] bits;
    rows = glyph_rows(digit);
    bits = '0;
    for (int r = 0; r < MATRIX_WIDTH; r++) begin
      row = rows[r*MATRIX_WIDTH +: MATRIX_WIDTH];
      bits[r*MATRIX_WIDTH + MATRIX_WIDTH - 1] = (col < 3'd5) ? row[col] : 1'b0;
    end
    return bits;
  endfunction

  // logical pixel r*5+c to physical led bit, per orientation
  function automatic logic [CELLS-1:0] to_physical(input logic [CELLS-1:0] logical,
                                                   input orient_t orient);
    logic [CELLS-1:0] rt;
    logic [CELLS-1:0] lt;
    logic [CELLS-1:0] fl;
    for (int r = 0; r < MATRIX_WIDTH; r++) begin
      for (int c = 0; c < MATRIX_WIDTH; c++) begin
        rt[20 - 5*c + r]        = logical[r*MATRIX_WIDTH + c];
        lt[4 + 5*c - r]         = logical[r*MATRIX_WIDTH + c];
        fl[24 - (5*r + c)]      = logical[r*MATRIX_WIDTH + c];
      end
    end
    case (orient)
      ORIENT_NORMAL: return logical;
      ORIENT_RIGHT:  return rt;
      ORIENT_LEFT:   return lt;
      ORIENT_FLIP:   return fl;
      default:       return logical;
    endcase
  endfunction

endpackage

// File: src/ldms_stream_if.sv
// valid/ready channel carrying one payload word
// no dependencies; payload type set by the instantiating code
`timescale 1ns / 1ps

interface ldms_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/ldms_front.sv
// front end: accepts a number and converts it to decimal digits (shift-add-3)
// depends on ldms_pkg and ldms_stream_if
`timescale 1ns / 1ps

module ldms_front #(
  parameter int MAX_DIGITS = ldms_pkg::MAX_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  ldms_stream_if.sink       number,
  output ldms_pkg::job_t    job,
  output logic              job_valid,
  input  logic              job_ready
);
  import ldms_pkg::*;

  localparam logic [CONV_CNT_W-1:0] LastStep = CONV_CNT_W'(VALUE_W - 1);
  localparam logic [2:0]            MaxCount = 3'(MAX_DIGITS);

  front_state_t          state;
  front_state_t          state_next;
  logic [VALUE_W-1:0]    sh;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [CONV_CNT_W-1:0] cnt;
  logic [2:0]            n_raw;
  logic                  take;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next   = state;
    number.ready = 1'b0;
    job_valid    = 1'b0;
    take         = 1'b0;
    case (state)
      F_IDLE: begin
        number.ready = 1'b1;
        if (number.valid) begin
          take       = 1'b1;
          state_next = F_CONV;
        end
      end
      F_CONV: begin
        if (cnt == LastStep) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        job_valid = 1'b1;
        if (job_ready) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      bcd_adj[k*4 +: 4] = (bcd[k*4 +: 4] >= 4'd5) ? bcd[k*4 +: 4] + 4'd3 : bcd[k*4 +: 4];
    end
  end

  // conversion datapath, one input bit per cycle
  always_ff @(posedge clk) begin
    if (take) begin
      sh  <= number.data.value;
      bcd <= '0;
      cnt <= '0;
    end else if (state == F_CONV) begin
      bcd <= {bcd_adj[BCD_W-2:0], sh[VALUE_W-1]};
      sh  <= {sh[VALUE_W-2:0], 1'b0};
      cnt <= cnt + 1'b1;
    end
  end

  // digit count without leading zeros, capped to the store depth
  always_comb begin
    n_raw = 3'd1;
    for (int k = 1; k < BCD_DIGITS; k++) begin
      if (bcd[k*4 +: 4] != 4'd0) begin
        n_raw = 3'(k + 1);
      end
    end
  end

  assign job.bcd   = bcd;
  assign job.count = (n_raw > MaxCount) ? MaxCount : n_raw;

endmodule

// File: src/ldms_queue.sv
// small word queue between the converter and the frame generator
// depends on ldms_pkg
`timescale 1ns / 1ps

module ldms_queue (
  input  logic           clk,
  input  logic           rst,
  input  ldms_pkg::job_t in_job,
  input  logic           in_valid,
  output logic           in_ready,
  output ldms_pkg::job_t out_job,
  output logic           out_valid,
  input  logic           out_ready
);
  import ldms_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(QUEUE_DEPTH);

  job_t            mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            push;
  logic            pop;

  assign in_ready  = (fill != Full);
  assign out_valid = (fill != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_job;
    end
  end

endmodule

// File: src/ldms_back.sv
// back end: builds the scrolling frames of one number and drives the output register
// depends on ldms_pkg, ldms_stream_if and assert_macros.svh
`timescale 1ns / 1ps

module ldms_back #(
  parameter int MAX_DIGITS = ldms_pkg::MAX_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ldms_pkg::job_t    job,
  input  logic              job_valid,
  output logic              job_ready,
  input  ldms_pkg::orient_t orientation,
  ldms_stream_if.source     frames
);
  import ldms_pkg::*;
  `include "assert_macros.svh"

  localparam int DptrW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [2:0] LastCol = 3'(MATRIX_WIDTH - 1);

  back_state_t      state;
  back_state_t      state_next;
  logic [3:0]       digit_store [MAX_DIGITS];
  logic [DptrW-1:0] dptr;
  logic [2:0]       col;
  logic             tail;
  logic [CELLS-1:0] column_frame;
  logic [CELLS-1:0] entering;
  logic [CELLS-1:0] frame_now;
  logic             step;
  logic             fin;
  logic             start;
  logic             out_valid;
  frame_word_t      out_word;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, frame step and end of run
  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    start      = 1'b0;
    step       = 1'b0;
    fin        = 1'b0;
    case (state)
      B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          start      = 1'b1;
          state_next = B_RUN;
        end
      end
      B_RUN: begin
        step = !out_valid || frames.ready;
        fin  = tail && (col == LastCol);
        if (step && fin) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // current frame: shifted columns plus the entering glyph column
  assign entering  = tail ? '0 : entering_column(digit_store[dptr], col);
  assign frame_now = column_frame | entering;

  // run bookkeeping: digit pointer counts down from the most significant digit
  always_ff @(posedge clk) begin
    if (start) begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
        digit_store[k] <= job.bcd[k];
      end
      dptr         <= DptrW'(job.count - 3'd1);
      col          <= '0;
      tail         <= 1'b0;
      column_frame <= '0;
    end else if (step) begin
      column_frame <= (frame_now >> 1) & KEEP_AFTER_SHIFT;
      if (col == LastCol) begin
        col <= '0;
        if (!tail) begin
          if (dptr == '0) begin
            tail <= 1'b1;
          end else begin
            dptr <= dptr - 1'b1;
          end
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (frames.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word.led_mask <= to_physical(frame_now, orientation);
      out_word.last     <= fin;
    end
  end

  assign frames.valid = out_valid;
  assign frames.data  = out_word;

  // checks
  `LDMS_ASSERT_NXT(a_last_ends_run, clk, rst, step && fin, state == B_IDLE, "run did not end after last frame")
  `LDMS_ASSERT_IMP(a_clean_start, clk, rst, state == B_RUN && $past(state) == B_IDLE, column_frame == '0 && col == '0 && !tail, "run started with stale frame")
  `LDMS_ASSERT_NXT(a_tail_follows_digits, clk, rst, step && !tail && dptr == '0 && col == LastCol, tail, "blank tail missing after last digit")

endmodule

// File: src/led_matrix_digit_scroller_unit.sv
// top level of the 5x5 led matrix digit scroller
// depends on ldms_pkg, ldms_stream_if, ldms_front, ldms_queue and ldms_back
//
// usage:
//   number : sink channel, one 16-bit unsigned value per word
//   frames : source channel, one word per frame (25-bit led mask, last flag)
//   cfg    : sink channel writing the 2-bit orientation; always ready
// a value with n decimal digits (no leading zeros, at most MAX_DIGITS of the
// least significant ones) gives 5*n + 5 frames, the final one with last set.
// the front end converts a value one input bit per cycle and holds it for the
// back end in a two-entry queue; it takes the next value in the cycle after it
// hands the current one over. the first frame shows once the value is converted,
// queued, picked up by the back end and registered at the output. while the
// receiver is ready the back end emits one frame per cycle, and it returns to
// idle to pick up the next value after the last frame of a run.
// when the receiver stalls, the output register holds its frame and the back
// end waits; the front end and queue keep taking values until both are full.
// reset (rst, synchronous) empties the queue, idles both ends and sets
// orientation to normal.
`timescale 1ns / 1ps

module led_matrix_digit_scroller_unit #(
  parameter int MAX_DIGITS = ldms_pkg::MAX_DIGITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ldms_stream_if.sink   number,
  ldms_stream_if.source frames,
  ldms_stream_if.sink   cfg
);
  import ldms_pkg::*;

  orient_t orientation;
  job_t    front_job;
  logic    front_valid;
  logic    front_ready;
  job_t    back_job;
  logic    back_valid;
  logic    back_ready;

  // orientation register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      orientation <= ORIENT_NORMAL;
    end else if (cfg.valid) begin
      orientation <= orient_t'(cfg.data.orientation);
    end
  end

  ldms_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .number    (number),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  ldms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_job    (front_job),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_job   (back_job),
    .out_valid (back_valid),
    .out_ready (back_ready)
  );

  ldms_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (back_job),
    .job_valid   (back_valid),
    .job_ready   (back_ready),
    .orientation (orientation),
    .frames      (frames)
  );

endmodule
